### hw/rtl/cfc_pkg.sv
// Shared constants and codes for the causal FIR convolver.
package cfc_pkg;

  localparam int DEF_MAX_TAPS = 32;

  localparam int SAMPLE_W  = 16;
  localparam int TAP_W     = 16;
  localparam int TAP_IDX_W = 5;
  localparam int TAP_CNT_W = 6;
  localparam int PROD_W    = SAMPLE_W + TAP_W;
  localparam int OUT_W     = 24;
  localparam int FRAC_BITS = 15;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = TAP_CNT_W'(1);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Half an output LSB, added before the arithmetic shift to round to nearest.
  localparam logic [FRAC_BITS:0] ROUND_BIAS = (FRAC_BITS + 1)'(1) << (FRAC_BITS - 1);

  // Input item commands.
  localparam logic CMD_LOAD_TAP = 1'b0;
  localparam logic CMD_SAMPLE   = 1'b1;

endpackage

### hw/rtl/cfc_if.sv
// Valid/ready channel interfaces for the input items, results and tap count register.

interface cfc_in_if import cfc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [TAP_W-1:0]    tap_value;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       row_start;

  modport source (output valid, command, tap_index, tap_value, sample, row_start,
                  input ready);
  modport sink (input valid, command, tap_index, tap_value, sample, row_start,
                output ready);
endinterface

interface cfc_out_if import cfc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;
  logic                    clipped;

  modport source (output valid, filtered, clipped, input ready);
  modport sink (input valid, filtered, clipped, output ready);
endinterface

interface cfc_cfg_if import cfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TAP_CNT_W-1:0] tap_count;

  modport source (output valid, tap_count, input ready);
  modport sink (input valid, tap_count, output ready);
endinterface

### hw/rtl/causal_fir_convolver_top.sv
// Top level of the causal FIR convolver: sequencer, shared multiply-accumulate and stores.
//
// Usage. Items arrive on the in_i channel and a beat is taken when valid and ready are
// both high. A load-tap beat (command low) writes one Q1.15 coefficient and gives no
// result; the block stays ready for the next item. A sample
// beat shifts the sample into the row history and gives exactly one result beat on
// out_o: the sum of the last min(tap_count, samples in the row) samples times the taps,
// rounded to nearest, shifted right by 15 and saturated to 24 bits, with clipped set
// when saturation changed it. row_start discards the history before the sample.
// The user writes the tap count register through cfg_i only while idle; it is not enforced.
// Throughput: one shared 16x16 multiplier does one tap per cycle (n taps in use, 1 to
// MAX_TAPS); the block takes no new item until the sample's result is formed. The steps
// are the n tap reads, the drain of the registered read, the multiply and the accumulate,
// then the rounding into the output register, which waits for that register to be free.
// With no taps in use the sequencer goes straight from the sample beat to the rounding.
// Reset clears the tap valid bits (so every tap reads as zero), the row fill and sets
// the tap count to one; no clearing pass is needed. A result that out_o does not take
// is held in the output register, and a new item is still accepted meanwhile; only the
// completion of the following sample waits for that register to be free.
module causal_fir_convolver_top import cfc_pkg::*; #(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input logic       clk_i,
  input logic       rst_ni,
  cfc_in_if.sink    in_i,
  cfc_out_if.source out_o,
  cfc_cfg_if.sink   cfg_i
);

  localparam int IDX_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W     = $clog2(MAX_TAPS + 1);
  localparam int CMP_W     = (CNT_W > TAP_CNT_W) ? CNT_W : TAP_CNT_W;
  localparam int ACC_MIN_W = PROD_W + $clog2(MAX_TAPS + 1);
  localparam int ACC_W     = (ACC_MIN_W > OUT_W + FRAC_BITS + 1) ? ACC_MIN_W
                                                                 : OUT_W + FRAC_BITS + 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(MAX_TAPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q;

  // Configuration.
  logic [TAP_CNT_W-1:0] tap_count_q;

  // Sequencer state.
  logic [CNT_W-1:0] fill_q;
  logic [CNT_W-1:0] taps_q;
  logic [CNT_W-1:0] rd_cnt_q;
  logic [IDX_W-1:0] wr_ptr_q;
  logic [IDX_W-1:0] rd_ptr_q;
  logic [MAX_TAPS-1:0] tap_vld_q;

  // Datapath.
  logic                     mul_vld_q;
  logic                     tap_ok_q;
  logic                     acc_vld_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Output register.
  logic                    out_vld_q;
  logic signed [OUT_W-1:0] filtered_q;
  logic                    clipped_q;

  logic in_fire, tap_fire, smp_fire, tap_in_range, issue, out_free;
  logic [IDX_W-1:0] wr_ptr_d;
  logic [CNT_W-1:0] fill_d;
  logic [CMP_W-1:0] n_cmp;
  logic [CNT_W-1:0] taps_d;

  logic             tap_we, hist_we;
  logic [IDX_W-1:0] tap_addr, hist_addr;
  logic [TAP_W-1:0]    tap_rdata;
  logic [SAMPLE_W-1:0] hist_rdata;

  logic signed [ACC_W:0] rounded;
  logic signed [ACC_W:0] shifted;
  logic                  clip_hi, clip_lo;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign in_fire      = in_i.valid && in_i.ready;
  assign tap_fire     = in_fire && (in_i.command == CMD_LOAD_TAP);
  assign smp_fire     = in_fire && (in_i.command == CMD_SAMPLE);
  assign tap_in_range = 32'(in_i.tap_index) < 32'(MAX_TAPS);
  assign issue        = (state_q == ST_RUN);
  assign out_free     = !out_vld_q || out_o.ready;

  // The newest sample goes one place on in the history ring.
  assign wr_ptr_d = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + IDX_W'(1);

  // Row fill after this sample, saturating at the store depth.
  always_comb begin
    if (in_i.row_start) begin
      fill_d = CNT_W'(1);
    end else if (fill_q == FILL_MAX) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + CNT_W'(1);
    end
  end

  // Taps in use: the smallest of the register, the store depth and the row fill.
  always_comb begin
    n_cmp = CMP_W'(tap_count_q);
    if (CMP_W'(FILL_MAX) < n_cmp) begin
      n_cmp = CMP_W'(FILL_MAX);
    end
    if (CMP_W'(fill_d) < n_cmp) begin
      n_cmp = CMP_W'(fill_d);
    end
    taps_d = CNT_W'(n_cmp);
  end

  // Memory port steering: writes while idle, reads while the sequencer runs.
  assign tap_we    = tap_fire && tap_in_range;
  assign hist_we   = smp_fire;
  assign tap_addr  = issue ? rd_cnt_q[IDX_W-1:0] : IDX_W'(in_i.tap_index);
  assign hist_addr = issue ? rd_ptr_q : wr_ptr_d;

  cfc_ram #(
    .WIDTH (TAP_W),
    .DEPTH (MAX_TAPS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .addr_i  (tap_addr),
    .wdata_i (in_i.tap_value),
    .rdata_o (tap_rdata)
  );

  cfc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .addr_i  (hist_addr),
    .wdata_i (in_i.sample),
    .rdata_o (hist_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      tap_count_q <= cfg_i.tap_count;
    end
  end

  // A tap never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_vld_q <= '0;
    end else if (tap_we) begin
      tap_vld_q[IDX_W'(in_i.tap_index)] <= 1'b1;
    end
  end

  // Signed product of the registered tap and history words.
  assign prod_d = $signed(tap_rdata) * $signed(hist_rdata);

  // Multiply stage on the registered memory data, then accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      tap_ok_q  <= 1'b0;
      acc_vld_q <= 1'b0;
      prod_q    <= '0;
      acc_q     <= '0;
    end else begin
      mul_vld_q <= issue;
      tap_ok_q  <= tap_vld_q[tap_addr];
      acc_vld_q <= mul_vld_q;
      prod_q    <= tap_ok_q ? prod_d : '0;
      if (smp_fire) begin
        acc_q <= '0;
      end else if (acc_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // Round to nearest with ties upward, shift and saturate.
  assign rounded = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(ROUND_BIAS);
  assign shifted = rounded >>> FRAC_BITS;
  assign clip_hi = shifted > (ACC_W + 1)'(OUT_MAX);
  assign clip_lo = shifted < (ACC_W + 1)'(OUT_MIN);

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      taps_q     <= '0;
      rd_cnt_q   <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      out_vld_q  <= 1'b0;
      filtered_q <= '0;
      clipped_q  <= 1'b0;
    end else begin
      if ((state_q == ST_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (smp_fire) begin
            fill_q   <= fill_d;
            taps_q   <= taps_d;
            wr_ptr_q <= wr_ptr_d;
            rd_ptr_q <= wr_ptr_d;
            rd_cnt_q <= '0;
            state_q  <= (taps_d == '0) ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          rd_cnt_q <= rd_cnt_q + CNT_W'(1);
          rd_ptr_q <= (rd_ptr_q == '0) ? LAST_IDX : rd_ptr_q - IDX_W'(1);
          if (rd_cnt_q + CNT_W'(1) == taps_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!mul_vld_q && !acc_vld_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            clipped_q  <= clip_hi || clip_lo;
            if (clip_hi) begin
              filtered_q <= OUT_MAX;
            end else if (clip_lo) begin
              filtered_q <= OUT_MIN;
            end else begin
              filtered_q <= shifted[OUT_W-1:0];
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.filtered = filtered_q;
  assign out_o.clipped  = clipped_q;

endmodule

### hw/rtl/cfc_ram.sv
// Generic single-port RAM with a registered read port.
module cfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/cfc_checker.sv
// Port-level checks on the causal FIR convolver, bound to its top level.
module cfc_checker import cfc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_command_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] out_filtered_i,
  input logic             out_clipped_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // A sample beat keeps the block busy for at least the following cycle.
  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_command_i == CMD_SAMPLE) |=> !in_ready_i)
    else $error("input ready straight after a sample beat");

  // A tap write never gives a result.
  a_no_result_for_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_command_i == CMD_LOAD_TAP) && !out_valid_i |=> !out_valid_i)
    else $error("result after a tap write");

  // A result never appears straight after its sample beat.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_command_i == CMD_SAMPLE) && !out_valid_i |=> !out_valid_i)
    else $error("result one cycle after a sample beat");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_filtered_i) && $stable(out_clipped_i))
    else $error("result beat changed while stalled");

endmodule

bind causal_fir_convolver_top cfc_checker u_cfc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_command_i   (in_i.command),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_filtered_i (out_o.filtered),
  .out_clipped_i  (out_o.clipped)
);
